### design/csv_line_field_parser_assert.svh
// Assertion macros for the CSV line parser. Clock clk_i and reset rst_ni are implied.
`ifndef CSV_LINE_FIELD_PARSER_ASSERT_SVH
`define CSV_LINE_FIELD_PARSER_ASSERT_SVH

`ifndef SYNTH
`define CSVLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CSVLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define CSVLP_ASSERT(lbl, prop, msg)
`define CSVLP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### design/csvlp_pkg.sv
`default_nettype none

package csvlp_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned CharCntW  = 8;
  localparam int unsigned FieldIdxW = 6;
  localparam int unsigned FieldCntW = 7;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [CharW-1:0] CharQuote = 8'h22;
  localparam logic [CharW-1:0] CharComma = 8'h2C;
  localparam logic [CharW-1:0] CharNul   = 8'h00;
  localparam logic [CharW-1:0] CharLf    = 8'h0A;
  localparam logic [CharW-1:0] CharCr    = 8'h0D;

  localparam logic [CfgIdxW-1:0] RegMaxFieldChars = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxColumns    = 2'd1;

  localparam logic [CharCntW-1:0]  MaxFieldCharsRst = 8'd15;
  localparam logic [FieldIdxW-1:0] MaxColumnsRst    = 6'd10;

  typedef enum logic [1:0] {
    ErrNone   = 2'd0,
    ErrLong   = 2'd1,
    ErrCols   = 2'd2,
    ErrFormat = 2'd3
  } err_e;

  typedef struct packed {
    logic [CharCntW-1:0]  max_field_chars;
    logic [FieldIdxW-1:0] max_columns;
  } cfg_t;

  typedef struct packed {
    logic [CharCntW-1:0]  char_count;
    logic [FieldIdxW-1:0] field_index;
    logic                 quoted_field;
    logic                 quote_closed;
    err_e                 line_error;
  } state_t;

  typedef struct packed {
    logic                 char_valid;
    logic [CharW-1:0]     char_out;
    logic                 field_done;
    logic [FieldIdxW-1:0] field_number;
    logic                 line_done;
    logic [FieldCntW-1:0] field_count;
    err_e                 error_code;
  } result_t;

endpackage

`default_nettype wire

### design/csvlp_if.sv
`default_nettype none

interface csvlp_char_if import csvlp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface csvlp_res_if import csvlp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 char_valid;
  logic [CharW-1:0]     char_out;
  logic                 field_done;
  logic [FieldIdxW-1:0] field_number;
  logic                 line_done;
  logic [FieldCntW-1:0] field_count;
  logic [1:0]           error_code;

  modport source (output valid, output char_valid, output char_out, output field_done,
                  output field_number, output line_done, output field_count,
                  output error_code, input ready);
  modport sink   (input valid, input char_valid, input char_out, input field_done,
                  input field_number, input line_done, input field_count,
                  input error_code, output ready);
endinterface

interface csvlp_cfg_if import csvlp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/csvlp_step.sv
`default_nettype none

module csvlp_step import csvlp_pkg::*; (
  input  var cfg_t             cfg_i,
  input  var state_t           state_i,
  input  wire [CharW-1:0]      char_i,
  output state_t               state_o,
  output result_t              result_o
);

  logic                 is_term;
  logic                 long_hit;
  logic [FieldIdxW-1:0] next_index;

  assign is_term    = (char_i == CharNul) || (char_i == CharLf) || (char_i == CharCr);
  assign long_hit   = state_i.char_count >= cfg_i.max_field_chars;
  assign next_index = state_i.field_index + FieldIdxW'(1);

  always_comb begin
    err_e err;
    err               = state_i.line_error;
    state_o           = state_i;
    result_o          = '0;
    result_o.field_number = state_i.field_index;

    if (is_term) begin
      result_o.line_done = 1'b1;
      if (err == ErrNone && state_i.quoted_field && !state_i.quote_closed) begin
        err = ErrFormat;
      end
      if (err == ErrNone) begin
        result_o.field_done  = 1'b1;
        result_o.field_count = {1'b0, state_i.field_index} + FieldCntW'(1);
      end
      result_o.error_code = err;
      state_o             = '0;
    end else begin
      if (err == ErrNone) begin
        if (char_i == CharQuote) begin
          if (state_i.char_count == '0 && !state_i.quoted_field) begin
            state_o.quoted_field = 1'b1;
          end else if (state_i.quoted_field) begin
            if (state_i.quote_closed) begin
              if (long_hit) begin
                err = ErrLong;
              end else begin
                result_o.char_valid  = 1'b1;
                result_o.char_out    = CharQuote;
                state_o.char_count   = state_i.char_count + CharCntW'(1);
                state_o.quote_closed = 1'b0;
              end
            end else begin
              state_o.quote_closed = 1'b1;
            end
          end else begin
            err = ErrFormat;
          end
        end else if (char_i == CharComma && state_i.quoted_field && !state_i.quote_closed) begin
          if (long_hit) begin
            err = ErrLong;
          end else begin
            result_o.char_valid = 1'b1;
            result_o.char_out   = CharComma;
            state_o.char_count  = state_i.char_count + CharCntW'(1);
          end
        end else if (char_i == CharComma) begin
          if (next_index >= cfg_i.max_columns) begin
            err = ErrCols;
          end else begin
            result_o.field_done  = 1'b1;
            state_o.field_index  = next_index;
            state_o.char_count   = '0;
            state_o.quoted_field = 1'b0;
            state_o.quote_closed = 1'b0;
          end
        end else if (state_i.quote_closed) begin
          err = ErrFormat;
        end else if (long_hit) begin
          err = ErrLong;
        end else begin
          result_o.char_valid = 1'b1;
          result_o.char_out   = char_i;
          state_o.char_count  = state_i.char_count + CharCntW'(1);
        end
      end
      state_o.line_error  = err;
      result_o.error_code = err;
      if (err != ErrNone) begin
        result_o.char_valid = 1'b0;
        result_o.char_out   = '0;
        result_o.field_done = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### design/csvlp_skid.sv
`default_nettype none

`include "csv_line_field_parser_assert.svh"

module csvlp_skid import csvlp_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_ready_o,
  input  var result_t  in_data_i,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output result_t      out_data_o
);

  logic    out_v_q;
  logic    skid_v_q;
  result_t main_q;
  result_t skid_q;
  logic    in_fire;

  assign in_ready_o  = !skid_v_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_v_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      out_v_q  <= skid_v_q || in_fire;
      skid_v_q <= 1'b0;
    end else if (in_fire) begin
      skid_v_q <= 1'b1;
    end
  end

  // advance the main stage from the skid stage first, else from the input
  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      main_q <= skid_v_q ? skid_q : in_data_i;
    end else if (in_fire) begin
      skid_q <= in_data_i;
    end
  end

  `CSVLP_ASSERT(a_skid_behind_main, !skid_v_q || out_v_q, "skid full with main empty")
  `CSVLP_ASSERT(a_stall_fills_skid, out_v_q && !out_ready_i && in_fire |=> skid_v_q,
                "stalled request not held in skid")

endmodule

`default_nettype wire

### design/csv_line_field_parser.sv
// CSV line field parser.
// in_i carries one byte of a CSV line per request; out_o returns one result per
// byte: an appended field character, a field close, a line end with the field
// count, and the line error code. cfg_i writes max_field_chars (index 0) and
// max_columns (index 1); other indexes are dropped. cfg_i is always ready and
// must only be written while no byte is in flight.
// A byte's result is registered in the main or, on a stall, the skid register.
// Throughput: one byte per cycle unless out_o stalls, set by the single per-byte
// state update between the line state registers and the output stage.
// The output stage is a main register plus one skid register, so in_i.ready
// depends only on registered state; when out_o stalls, one more byte is taken
// into the skid register and then in_i.ready drops until out_o drains.
// Reset (rst_ni low, asynchronous) clears the line state, empties both output
// registers and loads max_field_chars = 15 and max_columns = 10.
// A line terminator (NUL, LF or CR) clears the line state for the next line.
`default_nettype none

`include "csv_line_field_parser_assert.svh"

module csv_line_field_parser import csvlp_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  csvlp_cfg_if.sink   cfg_i,
  csvlp_char_if.sink  in_i,
  csvlp_res_if.source out_o
);

  cfg_t    cfg_q;
  state_t  state_q;
  state_t  state_d;
  result_t step_res;
  result_t out_res;
  logic    in_ready;
  logic    in_fire;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign in_fire     = in_i.valid && in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_field_chars <= MaxFieldCharsRst;
      cfg_q.max_columns     <= MaxColumnsRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegMaxFieldChars: cfg_q.max_field_chars <= cfg_i.data[CharCntW-1:0];
        RegMaxColumns:    cfg_q.max_columns     <= cfg_i.data[FieldIdxW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  csvlp_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .char_i   (in_i.char_in),
    .state_o  (state_d),
    .result_o (step_res)
  );

  csvlp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .in_data_i   (step_res),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_res)
  );

  assign out_o.char_valid   = out_res.char_valid;
  assign out_o.char_out     = out_res.char_out;
  assign out_o.field_done   = out_res.field_done;
  assign out_o.field_number = out_res.field_number;
  assign out_o.line_done    = out_res.line_done;
  assign out_o.field_count  = out_res.field_count;
  assign out_o.error_code   = out_res.error_code;

  `CSVLP_ASSERT(a_line_end_clears, in_fire && step_res.line_done |=> state_q == '0,
                "line state not cleared after terminator")
  `CSVLP_ASSERT(a_error_masks, step_res.error_code == ErrNone ||
                (!step_res.char_valid && !step_res.field_done),
                "character or close reported with an error")
  `CSVLP_ASSERT(a_count_on_clean_end, step_res.field_count == '0 ||
                (step_res.line_done && step_res.error_code == ErrNone),
                "field count outside a clean line end")

endmodule

`default_nettype wire
